/* rtl/gmgu_pkg.sv */
// Package for the majority-rule spin grid block: beat structs, opcodes, status codes,
// register indexes and state encoding.
// No dependencies; imported by glauber_majority_grid_update.
package gmgu_pkg;

    localparam int COORD_W  = 6;
    localparam int GRID_W   = 7;
    localparam int INT_W    = 6;
    localparam int COUNT_W  = 13;
    localparam int STATUS_W = 3;
    localparam int SUM_W    = 3;
    localparam int TIE_SUM  = 2;
    localparam int MIN_SIDE = 3;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    localparam logic [GRID_W-1:0]  GRID_SIZE_RST     = 7'd64;
    localparam logic [INT_W-1:0]   INTERIOR_SIZE_RST = 6'd32;
    localparam logic [COUNT_W-1:0] UPPER_COUNT_RST   = 13'd4096;
    localparam logic [COUNT_W-1:0] LOWER_COUNT_RST   = 13'd0;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_UPDATE = 1'b1
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_RUNNING     = 3'd0,
        ST_FIXED_ONES  = 3'd1,
        ST_FIXED_ZEROS = 3'd2,
        ST_IGNORED     = 3'd3,
        ST_BAD_COORD   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        REG_GRID_SIZE     = 2'd0,
        REG_INTERIOR_SIZE = 2'd1,
        REG_UPPER_COUNT   = 2'd2,
        REG_LOWER_COUNT   = 2'd3
    } t_reg_idx;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        t_opcode            opcode;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               load_value;
        logic               tie_bit;
    } t_in_beat;

    typedef struct packed {
        logic               site_value;
        logic [COUNT_W-1:0] interior_ones;
        t_status            status;
    } t_out_beat;

endpackage

/* rtl/glauber_majority_grid_update.sv */
// Top level of the majority-rule spin grid: row memories, sequencer, interior counter
// and APB register file.
// Depends on gmgu_pkg.
//
//   Channel  | Direction | Handshake                  | Beat
//   ---------+-----------+----------------------------+-----------
//   in       | input     | i_in_valid / o_in_stall    | t_in_beat
//   out      | output    | o_out_valid / i_out_stall  | t_out_beat
//   config   | input     | psel, penable, pwrite, ... | 32-bit APB
//
// Each item is handled in order: the accepting edge reads the three rows around the site
// from two copies of the row memory, and the write cycle then writes the row back and
// loads the result register. A held result stalls only the write cycle, so the next beat is
// still taken while a result waits. Reset and every grid_size or interior_size write
// clear the per-row valid bits at once, so no clearing pass is needed.
module glauber_majority_grid_update #(
    parameter int MAX_SIDE = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  gmgu_pkg::t_in_beat            i_in,
    output logic                          o_in_stall,
    output logic                          o_out_valid,
    output gmgu_pkg::t_out_beat           o_out,
    input  logic                          i_out_stall,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gmgu_pkg::APB_AW-1:0]   paddr,
    input  logic [gmgu_pkg::APB_DW-1:0]   pwdata,
    output logic [gmgu_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import gmgu_pkg::*;

    localparam int AW   = $clog2(MAX_SIDE);
    localparam int SW   = $clog2(MAX_SIDE + 1);
    localparam int NW   = (SW > GRID_W) ? SW : GRID_W;
    localparam logic [NW-1:0] SIDE_LO = NW'(MIN_SIDE);
    localparam logic [NW-1:0] SIDE_HI = NW'(MAX_SIDE);

    logic [GRID_W-1:0]  r_grid_size;
    logic [INT_W-1:0]   r_int_size;
    logic [COUNT_W-1:0] r_upper;
    logic [COUNT_W-1:0] r_lower;
    t_reg_idx           w_reg_idx;
    logic               w_cfg_wr;
    logic               w_geom_clr;

    logic [NW-1:0] w_side_raw, w_side, w_m_raw, w_m, w_lo;
    logic [NW-1:0] r_side, r_lo, r_hi;

    logic [MAX_SIDE-1:0] r_mem_a [MAX_SIDE];
    logic [MAX_SIDE-1:0] r_mem_b [MAX_SIDE];
    logic [MAX_SIDE-1:0] r_up_q, r_dn_q, r_mid_q;
    logic [MAX_SIDE-1:0] r_row_vld;

    t_state             r_state, n_state;
    t_in_beat           r_item;
    logic [COUNT_W-1:0] r_ones, n_ones;
    logic               r_done, n_done;
    logic               r_out_valid;
    t_out_beat          r_out, n_out;

    logic                w_in_acc, w_finish, w_wr_en, w_do_write;
    logic [AW-1:0]       w_acc_row, w_acc_up, w_acc_dn;
    logic [AW-1:0]       w_ridx, w_ridx_up, w_ridx_dn, w_cidx, w_cidx_l, w_cidx_r;
    logic [MAX_SIDE-1:0] w_up, w_dn, w_mid, w_wr_row;
    logic [NW-1:0]       w_row_n, w_col_n;
    logic                w_in_grid, w_inner, w_in_int, w_old, w_major, w_new_bit;
    logic [SUM_W-1:0]    w_sum;

    // Configuration port.
    assign pready     = 1'b1;
    assign w_reg_idx  = t_reg_idx'(paddr[APB_AW-1:2]);
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign w_geom_clr = w_cfg_wr &&
                        (w_reg_idx == REG_GRID_SIZE || w_reg_idx == REG_INTERIOR_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= GRID_SIZE_RST;
            r_int_size  <= INTERIOR_SIZE_RST;
            r_upper     <= UPPER_COUNT_RST;
            r_lower     <= LOWER_COUNT_RST;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_GRID_SIZE:     r_grid_size <= pwdata[GRID_W-1:0];
                REG_INTERIOR_SIZE: r_int_size  <= pwdata[INT_W-1:0];
                REG_UPPER_COUNT:   r_upper     <= pwdata[COUNT_W-1:0];
                REG_LOWER_COUNT:   r_lower     <= pwdata[COUNT_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_GRID_SIZE:     prdata = APB_DW'(r_grid_size);
            REG_INTERIOR_SIZE: prdata = APB_DW'(r_int_size);
            REG_UPPER_COUNT:   prdata = APB_DW'(r_upper);
            REG_LOWER_COUNT:   prdata = APB_DW'(r_lower);
        endcase
    end

    // Clamped geometry, registered in the cycle after the configuration registers.
    always_comb begin
        w_side_raw = NW'(r_grid_size);
        if (w_side_raw < SIDE_LO) begin
            w_side = SIDE_LO;
        end else if (w_side_raw > SIDE_HI) begin
            w_side = SIDE_HI;
        end else begin
            w_side = w_side_raw;
        end
        w_m_raw = NW'(r_int_size);
        if (w_m_raw == '0) begin
            w_m = NW'(1);
        end else if (w_m_raw > w_side) begin
            w_m = w_side;
        end else begin
            w_m = w_m_raw;
        end
        w_lo = (w_side - w_m) >> 1;
    end

    always_ff @(posedge i_clk) begin
        r_side <= w_side;
        r_lo   <= w_lo;
        r_hi   <= w_lo + w_m;
    end

    // Row memories: copy A serves the rows above and below, copy B the site's own row.
    assign w_acc_row = AW'(i_in.row);
    assign w_acc_up  = w_acc_row - 1'b1;
    assign w_acc_dn  = w_acc_row + 1'b1;

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_up_q  <= r_mem_a[w_acc_up];
            r_dn_q  <= r_mem_a[w_acc_dn];
            r_mid_q <= r_mem_b[w_acc_row];
            r_item  <= i_in;
        end
        if (w_wr_en) begin
            r_mem_a[w_ridx] <= w_wr_row;
            r_mem_b[w_ridx] <= w_wr_row;
        end
    end

    // Site evaluation during the write cycle.
    assign w_ridx    = AW'(r_item.row);
    assign w_ridx_up = w_ridx - 1'b1;
    assign w_ridx_dn = w_ridx + 1'b1;
    assign w_cidx    = AW'(r_item.col);
    assign w_cidx_l  = w_cidx - 1'b1;
    assign w_cidx_r  = w_cidx + 1'b1;
    assign w_row_n   = NW'(r_item.row);
    assign w_col_n   = NW'(r_item.col);

    assign w_mid = r_row_vld[w_ridx]    ? r_mid_q : '0;
    assign w_up  = r_row_vld[w_ridx_up] ? r_up_q  : '0;
    assign w_dn  = r_row_vld[w_ridx_dn] ? r_dn_q  : '0;
    assign w_old = w_mid[w_cidx];

    assign w_in_grid = (w_row_n < r_side) && (w_col_n < r_side);
    assign w_inner   = (w_row_n != '0) && (w_col_n != '0) &&
                       (w_row_n <= r_side - NW'(2)) && (w_col_n <= r_side - NW'(2));
    assign w_in_int  = (w_row_n >= r_lo) && (w_row_n < r_hi) &&
                       (w_col_n >= r_lo) && (w_col_n < r_hi);

    assign w_sum = SUM_W'(w_up[w_cidx]) + SUM_W'(w_dn[w_cidx]) +
                   SUM_W'(w_mid[w_cidx_l]) + SUM_W'(w_mid[w_cidx_r]);

    always_comb begin
        if (w_sum > SUM_W'(TIE_SUM)) begin
            w_major = 1'b1;
        end else if (w_sum < SUM_W'(TIE_SUM)) begin
            w_major = 1'b0;
        end else begin
            w_major = r_item.tie_bit;
        end
    end

    always_comb begin
        w_do_write          = 1'b0;
        w_new_bit           = w_old;
        n_ones              = r_ones;
        n_done              = r_done;
        n_out.site_value    = 1'b0;
        n_out.status        = ST_RUNNING;
        if (r_item.opcode == OP_LOAD) begin
            if (w_in_grid) begin
                w_do_write       = 1'b1;
                w_new_bit        = r_item.load_value;
                n_done           = 1'b0;
                n_out.site_value = r_item.load_value;
            end else begin
                n_out.status = ST_BAD_COORD;
            end
        end else begin
            n_out.site_value = w_in_grid ? w_old : 1'b0;
            if (r_done) begin
                n_out.status = ST_IGNORED;
            end else if (!w_inner) begin
                n_out.status = ST_BAD_COORD;
            end else begin
                w_do_write       = 1'b1;
                w_new_bit        = w_major;
                n_out.site_value = w_major;
            end
        end
        if (w_do_write && (w_new_bit != w_old) && w_in_int) begin
            if (w_new_bit) begin
                n_ones = r_ones + 1'b1;
            end else if (r_ones != '0) begin
                n_ones = r_ones - 1'b1;
            end
        end
        if (r_item.opcode == OP_UPDATE && w_do_write) begin
            if (n_ones >= r_upper) begin
                n_out.status = ST_FIXED_ONES;
                n_done       = 1'b1;
            end else if (n_ones <= r_lower) begin
                n_out.status = ST_FIXED_ZEROS;
                n_done       = 1'b1;
            end
        end
        n_out.interior_ones = n_ones;
        w_wr_row            = w_mid;
        w_wr_row[w_cidx]    = w_new_bit;
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!(r_out_valid && i_out_stall)) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        w_finish   = 1'b0;
        unique case (r_state)
            S_IDLE: o_in_stall = 1'b0;
            S_EXEC: w_finish   = !(r_out_valid && i_out_stall);
        endcase
    end

    assign w_in_acc = i_in_valid && !o_in_stall;
    assign w_wr_en  = w_finish && w_do_write;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ones      <= '0;
            r_done      <= 1'b0;
            r_row_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_geom_clr) begin
                r_row_vld <= '0;
                r_ones    <= '0;
                r_done    <= 1'b0;
            end else if (w_finish) begin
                r_ones <= n_ones;
                r_done <= n_done;
                if (w_do_write) begin
                    r_row_vld[w_ridx] <= 1'b1;
                end
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
